>>> rtl/tfn_pkg.sv
// Shared constants, payload types and inter-stage structs of the triangle face normal pipeline.
package tfn_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int NORMAL_WIDTH = 16;
    localparam int FRAC_W       = NORMAL_WIDTH - 1;

    localparam int EDGE_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int LEN_W   = $clog2(CROSS_W + 1);

    // leading-one search over the cross magnitudes, in groups
    localparam int GRP_W  = 8;
    localparam int GRP_N  = (CROSS_W + GRP_W - 1) / GRP_W;
    localparam int GLEN_W = $clog2(GRP_W + 1);

    localparam int SQ_IN_W = 30;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = SUM_W / 2;

    localparam int ISQ_STEPS  = ROOT_W;
    localparam int ISQ_PER    = 2;
    localparam int ISQ_STAGES = (ISQ_STEPS + ISQ_PER - 1) / ISQ_PER;

    localparam int DIV_W      = ROOT_W + 1;
    localparam int NUM_W      = SQ_IN_W + NORMAL_WIDTH + 1;
    localparam int QUO_W      = NORMAL_WIDTH + 1;
    localparam int DIV_PER    = 3;
    localparam int DIV_STAGES = (QUO_W + DIV_PER - 1) / DIV_PER;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] a_z;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] b_z;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
        logic signed [COORD_WIDTH-1:0] c_z;
        logic                          last_triangle;
    } tfn_in_t;

    typedef struct packed {
        logic signed [NORMAL_WIDTH-1:0] normal_x;
        logic signed [NORMAL_WIDTH-1:0] normal_y;
        logic signed [NORMAL_WIDTH-1:0] normal_z;
        logic                           degenerate;
        logic                           end_of_list;
    } tfn_out_t;

    typedef struct packed {
        logic [2:0][CROSS_W-1:0] mag;
        logic [2:0]              neg;
        logic                    last;
    } tfn_mag_t;

    typedef struct packed {
        logic [2:0][SQ_IN_W-1:0] mag;
        logic [SUM_W-1:0]        sum;
        logic [2:0]              neg;
        logic                    degen;
        logic                    last;
    } tfn_sq_t;

    typedef struct packed {
        logic [2:0][SQ_IN_W-1:0] mag;
        logic [ROOT_W-1:0]       len;
        logic [2:0]              neg;
        logic                    degen;
        logic                    last;
    } tfn_root_t;

endpackage

>>> rtl/tfn_cross.sv
// Frame swap, edge vectors, cross product and sign/magnitude split (4 stages).
module tfn_cross import tfn_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  tfn_in_t  in_data,
    output logic     out_valid,
    output tfn_mag_t out_data
);

    logic [3:0] v_reg;

    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [EDGE_W-1:0]  e1_next [3];
    logic signed [EDGE_W-1:0]  e2_next [3];
    logic signed [PROD_W-1:0]  p_reg [6];
    logic signed [CROSS_W-1:0] cr_reg [3];
    logic [2:0]                last_reg;
    tfn_mag_t                  out_reg;
    tfn_mag_t                  out_next;

    function automatic logic signed [COORD_WIDTH-1:0] neg_sat(logic signed [COORD_WIDTH-1:0] y);
        logic signed [COORD_WIDTH-1:0] r;
        if (y == {1'b1, {(COORD_WIDTH-1){1'b0}}}) begin
            r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end else begin
            r = -y;
        end
        return r;
    endfunction

    // Y-up vertex is (x, z, -y)
    always_comb begin
        e1_next[0] = EDGE_W'(in_data.a_x) - EDGE_W'(in_data.c_x);
        e1_next[1] = EDGE_W'(in_data.a_z) - EDGE_W'(in_data.c_z);
        e1_next[2] = EDGE_W'(neg_sat(in_data.a_y)) - EDGE_W'(neg_sat(in_data.c_y));
        e2_next[0] = EDGE_W'(in_data.b_x) - EDGE_W'(in_data.c_x);
        e2_next[1] = EDGE_W'(in_data.b_z) - EDGE_W'(in_data.c_z);
        e2_next[2] = EDGE_W'(neg_sat(in_data.b_y)) - EDGE_W'(neg_sat(in_data.c_y));
    end

    always_comb begin
        out_next.last = last_reg[2];
        for (int i = 0; i < 3; i++) begin
            out_next.neg[i] = cr_reg[i][CROSS_W-1];
            out_next.mag[i] = cr_reg[i][CROSS_W-1] ? CROSS_W'(-cr_reg[i]) : CROSS_W'(cr_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= e1_next[i];
                e2_reg[i] <= e2_next[i];
            end
            p_reg[0] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[2]);
            p_reg[1] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[1]);
            p_reg[2] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[0]);
            p_reg[3] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[2]);
            p_reg[4] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[1]);
            p_reg[5] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[0]);
            for (int i = 0; i < 3; i++) begin
                cr_reg[i] <= CROSS_W'(p_reg[2*i]) - CROSS_W'(p_reg[2*i+1]);
            end
            out_reg  <= out_next;
            last_reg <= {last_reg[1:0], in_data.last_triangle};
        end
    end

    assign out_valid = v_reg[3];
    assign out_data  = out_reg;

endmodule

>>> rtl/tfn_norm.sv
// Common right shift of the magnitudes to 30 bits and squared length (5 stages).
module tfn_norm import tfn_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  tfn_mag_t in_data,
    output logic     out_valid,
    output tfn_sq_t  out_data
);

    logic [4:0] v_reg;

    tfn_mag_t                m5_reg;
    logic [GRP_N-1:0]        gnz_reg;
    logic [GLEN_W-1:0]       glen_reg [GRP_N];
    logic                    degen5_reg;
    tfn_mag_t                m6_reg;
    logic [LEN_W-1:0]        sh_reg;
    logic                    degen6_reg;
    logic [2:0][SQ_IN_W-1:0] m7_reg;
    logic [2:0]              neg7_reg;
    logic                    last7_reg;
    logic                    degen7_reg;
    logic [2*SQ_IN_W-1:0]    sq_reg [3];
    logic [2:0][SQ_IN_W-1:0] m8_reg;
    logic [2:0]              neg8_reg;
    logic                    last8_reg;
    logic                    degen8_reg;
    tfn_sq_t                 out_reg;

    logic [GRP_N*GRP_W-1:0]  or_all;
    logic [GRP_N-1:0]        gnz_next;
    logic [GLEN_W-1:0]       glen_next [GRP_N];
    logic [LEN_W-1:0]        maxlen;
    logic [LEN_W-1:0]        sh_next;

    function automatic logic [GLEN_W-1:0] grp_len(logic [GRP_W-1:0] g);
        logic [GLEN_W-1:0] r;
        r = '0;
        for (int i = 0; i < GRP_W; i++) begin
            if (g[i]) r = GLEN_W'(i + 1);
        end
        return r;
    endfunction

    // bit length of the OR equals the largest bit length of the three
    always_comb begin
        or_all = (GRP_N*GRP_W)'(in_data.mag[0] | in_data.mag[1] | in_data.mag[2]);
        for (int g = 0; g < GRP_N; g++) begin
            gnz_next[g]  = |or_all[g*GRP_W +: GRP_W];
            glen_next[g] = grp_len(or_all[g*GRP_W +: GRP_W]);
        end
    end

    always_comb begin
        maxlen = '0;
        for (int g = 0; g < GRP_N; g++) begin
            if (gnz_reg[g]) maxlen = LEN_W'(g * GRP_W) + LEN_W'(glen_reg[g]);
        end
        sh_next = (maxlen > LEN_W'(SQ_IN_W)) ? maxlen - LEN_W'(SQ_IN_W) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m5_reg     <= in_data;
            gnz_reg    <= gnz_next;
            for (int g = 0; g < GRP_N; g++) glen_reg[g] <= glen_next[g];
            degen5_reg <= (or_all == '0);

            m6_reg     <= m5_reg;
            sh_reg     <= sh_next;
            degen6_reg <= degen5_reg;

            for (int i = 0; i < 3; i++) m7_reg[i] <= SQ_IN_W'(m6_reg.mag[i] >> sh_reg);
            neg7_reg   <= m6_reg.neg;
            last7_reg  <= m6_reg.last;
            degen7_reg <= degen6_reg;

            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= (2*SQ_IN_W)'(m7_reg[i]) * (2*SQ_IN_W)'(m7_reg[i]);
            end
            m8_reg     <= m7_reg;
            neg8_reg   <= neg7_reg;
            last8_reg  <= last7_reg;
            degen8_reg <= degen7_reg;

            out_reg.sum   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            out_reg.mag   <= m8_reg;
            out_reg.neg   <= neg8_reg;
            out_reg.last  <= last8_reg;
            out_reg.degen <= degen8_reg;
        end
    end

    assign out_valid = v_reg[4];
    assign out_data  = out_reg;

endmodule

>>> rtl/tfn_isqrt.sv
// Pipelined bitwise integer square root, two result bits per stage.
module tfn_isqrt import tfn_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  tfn_sq_t   in_data,
    output logic      out_valid,
    output tfn_root_t out_data
);

    typedef struct packed {
        logic [SUM_W-1:0]        n;
        logic [SUM_W-1:0]        res;
        logic [2:0][SQ_IN_W-1:0] mag;
        logic [2:0]              neg;
        logic                    degen;
        logic                    last;
    } isq_st_t;

    logic [ISQ_STAGES-1:0] v_reg;
    isq_st_t               st_reg  [ISQ_STAGES];
    isq_st_t               st_next [ISQ_STAGES];

    always_comb begin
        isq_st_t          cur;
        logic [SUM_W-1:0] bitv;
        int               k;
        for (int s = 0; s < ISQ_STAGES; s++) begin
            if (s == 0) begin
                cur.n     = in_data.sum;
                cur.res   = '0;
                cur.mag   = in_data.mag;
                cur.neg   = in_data.neg;
                cur.degen = in_data.degen;
                cur.last  = in_data.last;
            end else begin
                cur = st_reg[s-1];
            end
            for (int j = 0; j < ISQ_PER; j++) begin
                k = s * ISQ_PER + j;
                if (k < ISQ_STEPS) begin
                    bitv = SUM_W'(1) << (SUM_W - 2 - 2 * k);
                    if (cur.n >= cur.res + bitv) begin
                        cur.n   = cur.n - (cur.res + bitv);
                        cur.res = (cur.res >> 1) + bitv;
                    end else begin
                        cur.res = cur.res >> 1;
                    end
                end
            end
            st_next[s] = cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[ISQ_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < ISQ_STAGES; s++) st_reg[s] <= st_next[s];
        end
    end

    assign out_valid      = v_reg[ISQ_STAGES-1];
    assign out_data.len   = ROOT_W'(st_reg[ISQ_STAGES-1].res);
    assign out_data.mag   = st_reg[ISQ_STAGES-1].mag;
    assign out_data.neg   = st_reg[ISQ_STAGES-1].neg;
    assign out_data.degen = st_reg[ISQ_STAGES-1].degen;
    assign out_data.last  = st_reg[ISQ_STAGES-1].last;

endmodule

>>> rtl/tfn_div.sv
// Pipelined rounded division m/len in three lanes, then sign and saturation into the output register.
module tfn_div import tfn_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  tfn_root_t in_data,
    output logic      out_valid,
    output tfn_out_t  out_data
);

    typedef struct packed {
        logic [2:0][DIV_W-1:0] rem;
        logic [2:0][QUO_W-1:0] low;
        logic [2:0][QUO_W-1:0] q;
        logic [DIV_W-1:0]      d;
        logic [2:0]            neg;
        logic                  degen;
        logic                  last;
    } div_st_t;

    localparam logic [QUO_W-1:0] FULL = QUO_W'(1) << FRAC_W;

    logic [DIV_STAGES:0] v_reg;
    div_st_t             st_reg  [DIV_STAGES];
    div_st_t             st_next [DIV_STAGES];
    tfn_out_t            out_reg;
    tfn_out_t            out_next;

    // q = floor((m * 2^(F+1) + len) / (2 * len)), at most 2^F, so QUO_W bits suffice
    always_comb begin
        div_st_t          cur;
        logic [NUM_W-1:0] num;
        logic [DIV_W:0]   t;
        int               k;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                cur.d = {in_data.len, 1'b0};
                for (int i = 0; i < 3; i++) begin
                    num = NUM_W'({in_data.mag[i], {NORMAL_WIDTH{1'b0}}}) + NUM_W'(in_data.len);
                    cur.rem[i] = DIV_W'(num[NUM_W-1:QUO_W]);
                    cur.low[i] = num[QUO_W-1:0];
                    cur.q[i]   = '0;
                end
                cur.neg   = in_data.neg;
                cur.degen = in_data.degen;
                cur.last  = in_data.last;
            end else begin
                cur = st_reg[s-1];
            end
            for (int j = 0; j < DIV_PER; j++) begin
                k = s * DIV_PER + j;
                if (k < QUO_W) begin
                    for (int i = 0; i < 3; i++) begin
                        t          = {cur.rem[i], cur.low[i][QUO_W-1]};
                        cur.low[i] = cur.low[i] << 1;
                        if (t >= {1'b0, cur.d}) begin
                            cur.rem[i] = DIV_W'(t - {1'b0, cur.d});
                            cur.q[i]   = {cur.q[i][QUO_W-2:0], 1'b1};
                        end else begin
                            cur.rem[i] = DIV_W'(t);
                            cur.q[i]   = {cur.q[i][QUO_W-2:0], 1'b0};
                        end
                    end
                end
            end
            st_next[s] = cur;
        end
    end

    always_comb begin
        div_st_t                  fin;
        logic [QUO_W-1:0]         qc [3];
        logic signed [NORMAL_WIDTH-1:0] nv [3];
        fin = st_reg[DIV_STAGES-1];
        for (int i = 0; i < 3; i++) begin
            qc[i] = (fin.q[i] > FULL) ? FULL : fin.q[i];
            // output sign is opposite to the cross component
            if (fin.degen) begin
                nv[i] = '0;
            end else if (fin.neg[i]) begin
                nv[i] = (qc[i] > FULL - 1'b1) ? NORMAL_WIDTH'(FULL - 1'b1) : NORMAL_WIDTH'(qc[i]);
            end else begin
                nv[i] = NORMAL_WIDTH'(-qc[i]);
            end
        end
        out_next.normal_x    = nv[0];
        out_next.normal_y    = nv[1];
        out_next.normal_z    = nv[2];
        out_next.degenerate  = fin.degen;
        out_next.end_of_list = fin.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[DIV_STAGES-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < DIV_STAGES; s++) st_reg[s] <= st_next[s];
            out_reg <= out_next;
        end
    end

    assign out_valid = v_reg[DIV_STAGES];
    assign out_data  = out_reg;

endmodule

>>> rtl/triangle_face_normal.sv
// Top level of the triangle face normal pipeline.
// One triangle per request enters each cycle while the pipeline is not held; its unit normal
// (Q1.15, Y-up frame, negated cross product of a-c and b-c) passes through edge and cross
// product, magnitude shift and squared length, square root at two bits per stage, division at
// three quotient bits per stage and the output register. The whole pipeline holds
// while a result waits on m_ready; s_ready follows that. A zero cross product gives a zero
// normal with degenerate set. The block keeps no state between triangles.
module triangle_face_normal import tfn_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tfn_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tfn_out_t m_data
);

    logic      en;
    logic      cross_valid;
    tfn_mag_t  cross_data;
    logic      norm_valid;
    tfn_sq_t   norm_data;
    logic      root_valid;
    tfn_root_t root_data;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    tfn_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (cross_valid),
        .out_data  (cross_data)
    );

    tfn_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cross_valid),
        .in_data   (cross_data),
        .out_valid (norm_valid),
        .out_data  (norm_data)
    );

    tfn_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (norm_valid),
        .in_data   (norm_data),
        .out_valid (root_valid),
        .out_data  (root_data)
    );

    tfn_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (root_valid),
        .in_data   (root_data),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            (m_data.normal_x == 0 && m_data.normal_y == 0 && m_data.normal_z == 0))
        else $error("degenerate request with nonzero normal");

    a_unit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.degenerate |->
            (m_data.normal_x != 0 || m_data.normal_y != 0 || m_data.normal_z != 0))
        else $error("non-degenerate request gave a zero normal");

    a_reset_empty: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule
